// File: rtl/core/single_wire_rgb_led_decoder_assert.svh
// ---------------------------------------------------------------------------
// Single-wire RGB LED decoder assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef SINGLE_WIRE_RGB_LED_DECODER_ASSERT_SVH
`define SINGLE_WIRE_RGB_LED_DECODER_ASSERT_SVH

// Same-cycle implication.
`define SWRGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWRGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/swrgb_pkg.sv
// ---------------------------------------------------------------------------
// swrgb_pkg
// Shared types, constants and timing window helpers of the LED decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package swrgb_pkg;

    // Upper bound on LEDs consumed before forwarding
    localparam logic [10:0] MAX_LEDS = 11'd1024;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_NS     = 3'd0;
    localparam logic [2:0] CFG_ZERO_HIGH_NS = 3'd1;
    localparam logic [2:0] CFG_ONE_HIGH_NS  = 3'd2;
    localparam logic [2:0] CFG_ZERO_LOW_NS  = 3'd3;
    localparam logic [2:0] CFG_ONE_LOW_NS   = 3'd4;
    localparam logic [2:0] CFG_TOLERANCE_NS = 3'd5;
    localparam logic [2:0] CFG_LED_COUNT    = 3'd6;

    // Reset values of the configuration registers
    localparam logic [19:0] RESET_NS_DFLT     = 20'd50000;
    localparam logic [11:0] ZERO_HIGH_NS_DFLT = 12'd400;
    localparam logic [11:0] ONE_HIGH_NS_DFLT  = 12'd850;
    localparam logic [11:0] ZERO_LOW_NS_DFLT  = 12'd850;
    localparam logic [11:0] ONE_LOW_NS_DFLT   = 12'd400;
    localparam logic [9:0]  TOLERANCE_NS_DFLT = 10'd150;
    localparam logic [10:0] LED_COUNT_DFLT    = 11'd1;

    // Byte slots within one LED, in wire order
    localparam logic [1:0] BYTE_GREEN = 2'd0;
    localparam logic [1:0] BYTE_RED   = 2'd1;
    localparam logic [1:0] BYTE_BLUE  = 2'd2;

    typedef struct packed {
        logic [19:0] reset_ns;
        logic [11:0] zero_high_ns;
        logic [11:0] one_high_ns;
        logic [11:0] zero_low_ns;
        logic [11:0] one_low_ns;
        logic [9:0]  tolerance_ns;
        logic [10:0] led_count;
    } swrgb_cfg_t;

    typedef struct packed {
        logic       drive_valid;
        logic       drive_level;
        logic       led_valid;
        logic [9:0] led_number;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } swrgb_result_t;

    // t > nom - tol, with a negative bound admitting everything
    function automatic logic above_low(input logic [19:0] t, input logic [11:0] nom,
                                       input logic [9:0] tol);
        logic [12:0] diff;
        diff = {1'b0, nom} - {3'b000, tol};
        return diff[12] || (t > {7'b0000000, diff});
    endfunction

    // t < nom + tol
    function automatic logic below_high(input logic [19:0] t, input logic [11:0] nom,
                                        input logic [9:0] tol);
        logic [12:0] sum;
        sum = {1'b0, nom} + {3'b000, tol};
        return t < {7'b0000000, sum};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/swrgb_cfg_regs.sv
// ---------------------------------------------------------------------------
// swrgb_cfg_regs
// Configuration register file written through its own valid/ready channel.
// ---------------------------------------------------------------------------
`default_nettype none

module swrgb_cfg_regs
    import swrgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data,
    output swrgb_cfg_t       cfg
);

    swrgb_cfg_t cfg_reg;
    swrgb_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RESET_NS:     cfg_next.reset_ns     = cfg_data;
                CFG_ZERO_HIGH_NS: cfg_next.zero_high_ns = cfg_data[11:0];
                CFG_ONE_HIGH_NS:  cfg_next.one_high_ns  = cfg_data[11:0];
                CFG_ZERO_LOW_NS:  cfg_next.zero_low_ns  = cfg_data[11:0];
                CFG_ONE_LOW_NS:   cfg_next.one_low_ns   = cfg_data[11:0];
                CFG_TOLERANCE_NS: cfg_next.tolerance_ns = cfg_data[9:0];
                CFG_LED_COUNT:    cfg_next.led_count    = cfg_data[10:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_ns     <= RESET_NS_DFLT;
            cfg_reg.zero_high_ns <= ZERO_HIGH_NS_DFLT;
            cfg_reg.one_high_ns  <= ONE_HIGH_NS_DFLT;
            cfg_reg.zero_low_ns  <= ZERO_LOW_NS_DFLT;
            cfg_reg.one_low_ns   <= ONE_LOW_NS_DFLT;
            cfg_reg.tolerance_ns <= TOLERANCE_NS_DFLT;
            cfg_reg.led_count    <= LED_COUNT_DFLT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/swrgb_decode.sv
// ---------------------------------------------------------------------------
// swrgb_decode
// Edge classifier, bit assembler and frame state; one edge per enable.
// ---------------------------------------------------------------------------
`default_nettype none

module swrgb_decode
    import swrgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step_en,
    input  wire logic        edge_rising,
    input  wire logic [19:0] interval_ns,
    input  swrgb_cfg_t       cfg,
    output swrgb_result_t    res
);

    logic [7:0]  shift_reg,   shift_next;
    logic [2:0]  bit_pos_reg, bit_pos_next;
    logic [1:0]  byte_pos_reg, byte_pos_next;
    logic [10:0] leds_reg,    leds_next;
    logic [7:0]  green_reg,   green_next;
    logic [7:0]  red_reg,     red_next;
    logic        long_reg,    long_next;
    logic        pending_reg, pending_next;

    logic [10:0] limit;
    logic        filled;
    logic        do_store;
    logic        store_val;
    logic [7:0]  set_byte;

    assign limit  = (cfg.led_count > MAX_LEDS) ? MAX_LEDS : cfg.led_count;
    assign filled = leds_reg >= limit;

    always_comb
    begin
        shift_next    = shift_reg;
        bit_pos_next  = bit_pos_reg;
        byte_pos_next = byte_pos_reg;
        leds_next     = leds_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        long_next     = long_reg;
        pending_next  = pending_reg;
        res           = '0;
        do_store      = 1'b0;
        store_val     = 1'b0;
        set_byte      = shift_reg;

        if (edge_rising)
        begin
            if (interval_ns > cfg.reset_ns)
            begin
                // long low gap: restart the frame
                shift_next    = '0;
                leds_next     = '0;
                byte_pos_next = BYTE_GREEN;
                bit_pos_next  = 3'd7;
            end
            else if (above_low(interval_ns, cfg.one_low_ns, cfg.tolerance_ns) &&
                     below_high(interval_ns, cfg.zero_low_ns, cfg.tolerance_ns))
            begin
                if (filled)
                begin
                    res.drive_valid = 1'b1;
                    res.drive_level = 1'b1;
                end
                else if (pending_reg)
                begin
                    if (long_reg)
                    begin
                        if (below_high(interval_ns, cfg.one_low_ns, cfg.tolerance_ns))
                        begin
                            do_store  = 1'b1;
                            store_val = 1'b1;
                        end
                    end
                    else if (above_low(interval_ns, cfg.zero_low_ns, cfg.tolerance_ns))
                    begin
                        do_store  = 1'b1;
                        store_val = 1'b0;
                    end
                end
            end
            pending_next = 1'b1;
        end
        else
        begin
            if (filled)
            begin
                res.drive_valid = 1'b1;
                res.drive_level = 1'b0;
            end
            else if (above_low(interval_ns, cfg.zero_high_ns, cfg.tolerance_ns) &&
                     below_high(interval_ns, cfg.one_high_ns, cfg.tolerance_ns))
            begin
                long_next = above_low(interval_ns, cfg.one_high_ns, cfg.tolerance_ns);
                // last bit of an LED has no bounded low time: take it now
                if (byte_pos_reg >= BYTE_BLUE && bit_pos_reg == 3'd0)
                begin
                    do_store     = 1'b1;
                    store_val    = long_next;
                    pending_next = 1'b0;
                end
            end
        end

        if (do_store)
        begin
            set_byte[bit_pos_reg] = store_val;
            if (bit_pos_reg != 3'd0)
            begin
                shift_next   = set_byte;
                bit_pos_next = bit_pos_reg - 3'd1;
            end
            else
            begin
                bit_pos_next = 3'd7;
                shift_next   = '0;
                unique case (byte_pos_reg)
                    BYTE_GREEN:
                    begin
                        green_next    = set_byte;
                        byte_pos_next = BYTE_RED;
                    end
                    BYTE_RED:
                    begin
                        red_next      = set_byte;
                        byte_pos_next = BYTE_BLUE;
                    end
                    default:
                    begin
                        res.led_valid  = 1'b1;
                        res.led_number = leds_reg[9:0];
                        res.red        = red_reg;
                        res.green      = green_reg;
                        res.blue       = set_byte;
                        byte_pos_next  = BYTE_GREEN;
                        leds_next      = leds_reg + 11'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= '0;
            bit_pos_reg  <= 3'd7;
            byte_pos_reg <= BYTE_GREEN;
            leds_reg     <= '0;
            green_reg    <= '0;
            red_reg      <= '0;
            long_reg     <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            shift_reg    <= shift_next;
            bit_pos_reg  <= bit_pos_next;
            byte_pos_reg <= byte_pos_next;
            leds_reg     <= leds_next;
            green_reg    <= green_next;
            red_reg      <= red_next;
            long_reg     <= long_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/single_wire_rgb_led_decoder.sv
// ---------------------------------------------------------------------------
// single_wire_rgb_led_decoder
// Decoder for a single-wire NRZ RGB LED stream with pass-through output.
// ---------------------------------------------------------------------------
// One transaction on the input channel carries one edge of the data wire:
// its direction and the time in ns since the previous edge. Every input
// transaction yields exactly one output transaction, in order. The block
// accepts one edge per clock cycle while the result register is free or
// being drained by out_ready; an accepted edge waits in the input register
// and moves into the result register when that slot is free or being
// drained, and its result is then presented on out_valid. The result
// register lets the next edge enter while a finished result waits for
// out_ready. Throughput is set only by the single
// pass of compare and update logic between those two registers. A result
// reports either a completed LED (index plus green, red, blue bytes, taken in
// that wire order) or, once the configured LED count is reached, the level
// to forward on the output pin; unused fields read zero. Write configuration
// only while no transaction is in flight; cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module single_wire_rgb_led_decoder
    import swrgb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // edge input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        edge_rising,
    input  wire logic [19:0] interval_ns,

    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             drive_valid,
    output logic             drive_level,
    output logic             led_valid,
    output logic [9:0]       led_number,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,

    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [19:0] cfg_data
);

    swrgb_cfg_t    cfg;
    swrgb_result_t step_res;

    // input register
    logic          in_valid_reg;
    logic          edge_reg;
    logic [19:0]   interval_reg;

    // result register
    logic          out_valid_reg;
    swrgb_result_t res_reg;

    logic          advance;

    // Move the held edge into the result register when that slot is free
    // or being drained this cycle; decoder state updates with the same step.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    swrgb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swrgb_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .edge_rising (edge_reg),
        .interval_ns (interval_reg),
        .cfg         (cfg),
        .res         (step_res)
    );

    // Hold the accepted edge until the decoder takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            edge_reg     <= edge_rising;
            interval_reg <= interval_ns;
        end
    end

    // Result register: load on advance, drop on acceptance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_valid = res_reg.drive_valid;
    assign drive_level = res_reg.drive_level;
    assign led_valid   = res_reg.led_valid;
    assign led_number  = res_reg.led_number;
    assign red         = res_reg.red;
    assign green       = res_reg.green;
    assign blue        = res_reg.blue;

endmodule

`default_nettype wire

// File: rtl/core/swrgb_checker.sv
// ---------------------------------------------------------------------------
// swrgb_checker
// Port-level checks of the LED decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "single_wire_rgb_led_decoder_assert.svh"

module swrgb_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        drive_valid,
    input wire logic        drive_level,
    input wire logic        led_valid,
    input wire logic [9:0]  led_number,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue
);

    // a stalled result holds its payload
    `SWRGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable({drive_valid, drive_level, led_valid, led_number, red, green, blue}),
        "result changed while stalled")

    // forwarding and LED reporting never coincide
    `SWRGB_ASSERT_NOW(a_excl, out_valid, !(drive_valid && led_valid),
        "pin drive and LED report in one result")

    // an undriven pin reads low
    `SWRGB_ASSERT_NOW(a_drive_zero, out_valid && !drive_valid, !drive_level,
        "drive level set without drive")

    // LED fields are zero without an LED report
    `SWRGB_ASSERT_NOW(a_led_zero, out_valid && !led_valid,
        led_number == 10'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0,
        "LED fields set without LED report")

endmodule

bind single_wire_rgb_led_decoder swrgb_checker u_swrgb_checker (.*);

`default_nettype wire
